/* design/spq_pkg.sv */
// shared types and constants of the stable priority queue
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 5;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed
    {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } entry_t;

    // broadcast to every cell of the row
    typedef struct packed
    {
        logic               ins;
        logic               del;
        entry_t             item;
        logic [CNT_W-1:0]   count;
    } cell_cmd_t;

endpackage

/* design/spq_cell.sv */
// one slot of the sorted row: holds an entry and shifts left or right
module spq_cell
(
    input  logic                     clk,
    input  logic [spq_pkg::CNT_W-1:0] idx,
    input  spq_pkg::cell_cmd_t       cmd,
    input  logic                     left_place,
    input  spq_pkg::entry_t          left_entry,
    input  spq_pkg::entry_t          right_entry,
    output logic                     place,
    output spq_pkg::entry_t          entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            occupied;

    // new item lands at or before this slot
    assign occupied = idx < cmd.count;
    assign place    = !occupied || (entry_reg.prio > cmd.item.prio);
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (left_place)
            begin
                entry_next = left_entry;
            end
            else if (place)
            begin
                entry_next = cmd.item;
            end
        end
        else if (cmd.del)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* design/stable_priority_queue.sv */
// top level: stable sorted priority queue built from a row of slot cells
// result: the strobe for a request is registered and rises in the cycle after the request is taken
// throughput: one request per cycle, busy stays low; every cell updates in parallel
// reset: rst_n clears the entry count and the result strobe, slot contents are left as they are
// the receiver cannot stall, each result is shown for exactly one cycle
module stable_priority_queue
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                operation,
    input  logic signed [spq_pkg::VALUE_W-1:0]  value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   priority_req,
    output logic                                done,
    output logic signed [spq_pkg::VALUE_W-1:0]  removed_value,
    output logic [1:0]                          status,
    output logic [spq_pkg::OCC_W-1:0]           occupancy
);

    // slot count and result registers
    logic [spq_pkg::CNT_W-1:0]          count_reg;
    logic [spq_pkg::CNT_W-1:0]          count_next;
    logic                               done_reg;
    logic signed [spq_pkg::VALUE_W-1:0] removed_reg;
    logic signed [spq_pkg::VALUE_W-1:0] removed_next;
    spq_pkg::status_t                   status_reg;
    spq_pkg::status_t                   status_next;
    logic [spq_pkg::OCC_W-1:0]          occupancy_reg;

    logic               accept;
    logic               full;
    logic               empty;
    spq_pkg::cell_cmd_t cmd;

    // the row of cells and the links between neighbours
    logic            place_w [spq_pkg::CAPACITY];
    spq_pkg::entry_t entry_w [spq_pkg::CAPACITY];

    // every cell updates in parallel, so a request is never held off
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = count_reg == spq_pkg::CNT_W'(spq_pkg::CAPACITY);
    assign empty  = count_reg == '0;

    always_comb
    begin
        cmd.ins        = accept && (spq_pkg::op_t'(operation) == spq_pkg::OP_INSERT) && !full;
        cmd.del        = accept && (spq_pkg::op_t'(operation) == spq_pkg::OP_DELETE) && !empty;
        cmd.item.value = value;
        cmd.item.prio  = priority_req;
        cmd.count      = count_reg;
    end

    // result of the current request
    always_comb
    begin
        count_next   = count_reg;
        removed_next = '0;
        status_next  = spq_pkg::ST_DONE;
        if (spq_pkg::op_t'(operation) == spq_pkg::OP_INSERT)
        begin
            if (full)
            begin
                status_next = spq_pkg::ST_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = spq_pkg::ST_EMPTY;
            end
            else
            begin
                // front cell holds the lowest priority, oldest first
                removed_next = entry_w[0].value;
                count_next   = count_reg - 1'b1;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < spq_pkg::CAPACITY; gi++)
        begin : g_cell
            logic            left_place;
            spq_pkg::entry_t left_entry;
            spq_pkg::entry_t right_entry;

            if (gi == 0)
            begin : g_first
                // nothing to the left: the front cell never takes a shifted entry
                assign left_place = 1'b0;
                assign left_entry = entry_w[0];
            end
            else
            begin : g_mid
                assign left_place = place_w[gi-1];
                assign left_entry = entry_w[gi-1];
            end

            if (gi == spq_pkg::CAPACITY - 1)
            begin : g_last
                // last slot falls out of use on delete, contents do not matter
                assign right_entry = entry_w[gi];
            end
            else
            begin : g_inner
                assign right_entry = entry_w[gi+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .idx         (spq_pkg::CNT_W'(gi)),
                .cmd         (cmd),
                .left_place  (left_place),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .place       (place_w[gi]),
                .entry       (entry_w[gi])
            );
        end
    endgenerate

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // result payload, only meaningful alongside the strobe
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_reg   <= removed_next;
            status_reg    <= status_next;
            occupancy_reg <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign done          = done_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign occupancy     = occupancy_reg;

endmodule

/* design/spq_check.sv */
// port-level checks for the stable priority queue and their binding
module spq_check
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic signed [spq_pkg::VALUE_W-1:0]  removed_value,
    input logic [1:0]                          status,
    input logic [spq_pkg::OCC_W-1:0]           occupancy
);

    // every request gives exactly one result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("request without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without request");

    // delete on empty leaves nothing behind and returns zero
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == spq_pkg::ST_EMPTY) |-> (removed_value == '0 && occupancy == '0))
        else $error("bad empty report");

    // dropped insert only when the store is full
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == spq_pkg::ST_FULL)
            |-> (removed_value == '0
                 && occupancy == spq_pkg::OCC_W'(spq_pkg::CAPACITY)))
        else $error("bad full report");

endmodule

bind stable_priority_queue spq_check u_spq_check
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .removed_value (removed_value),
    .status        (status),
    .occupancy     (occupancy)
);
